// ===== hw/rtl/rmc_pkg.sv =====
// shared types and constants for the register machine core
package rmc_pkg;

	localparam int MemWords = 32768;
	localparam int RegCount = 32;
	localparam int RetDepth = 256;
	localparam int MemAw = $clog2(MemWords);
	localparam int RegAw = $clog2(RegCount);
	localparam int SpW = $clog2(RetDepth);

	localparam logic [1:0] REQ_WRITE = 2'd0;
	localparam logic [1:0] REQ_READ = 2'd1;
	localparam logic [1:0] REQ_STEP = 2'd2;

	localparam logic [1:0] STOP_RUN = 2'd0;
	localparam logic [1:0] STOP_HALT = 2'd1;
	localparam logic [1:0] STOP_DUMP = 2'd2;
	localparam logic [1:0] STOP_INVALID = 2'd3;

	localparam logic [15:0] OP_LDC = 16'd0;
	localparam logic [15:0] OP_LD = 16'd1;
	localparam logic [15:0] OP_ST = 16'd2;
	localparam logic [15:0] OP_CP = 16'd3;
	localparam logic [15:0] OP_IN = 16'd4;
	localparam logic [15:0] OP_OUT = 16'd5;
	localparam logic [15:0] OP_INC = 16'd6;
	localparam logic [15:0] OP_DEC = 16'd7;
	localparam logic [15:0] OP_ADD = 16'd8;
	localparam logic [15:0] OP_SUB = 16'd9;
	localparam logic [15:0] OP_MUL = 16'd10;
	localparam logic [15:0] OP_DIV = 16'd11;
	localparam logic [15:0] OP_MOD = 16'd12;
	localparam logic [15:0] OP_AND = 16'd13;
	localparam logic [15:0] OP_OR = 16'd14;
	localparam logic [15:0] OP_XOR = 16'd15;
	localparam logic [15:0] OP_NOT = 16'd16;
	localparam logic [15:0] OP_LSH = 16'd17;
	localparam logic [15:0] OP_RSH = 16'd18;
	localparam logic [15:0] OP_BEQ = 16'd19;
	localparam logic [15:0] OP_BNE = 16'd20;
	localparam logic [15:0] OP_BGT = 16'd21;
	localparam logic [15:0] OP_BGE = 16'd22;
	localparam logic [15:0] OP_BLT = 16'd23;
	localparam logic [15:0] OP_BLE = 16'd24;
	localparam logic [15:0] OP_EXEC = 16'd25;
	localparam logic [15:0] OP_JUMP = 16'd26;
	localparam logic [15:0] OP_CALL = 16'd27;
	localparam logic [15:0] OP_RET = 16'd28;
	localparam logic [15:0] OP_HALT = 16'd29;
	localparam logic [15:0] OP_DUMP = 16'd30;

	// memory port selector
	typedef enum logic [1:0] {
		MA_REQ = 2'd0,
		MA_PC = 2'd1,
		MA_OPY = 2'd2,
		MA_OPX = 2'd3
	} maddr_sel_t;

	// controller to datapath commands
	typedef struct packed {
		logic       load_req;   // capture input item
		logic       mem_rd;     // issue memory read
		maddr_sel_t mem_sel;
		logic       mem_wr_req; // write item
		logic       mem_wr_st;  // st instruction
		logic       pc_inc;
		logic [1:0] opnd_wr;    // capture fetched word: 0 op 1 x 2 y 3 z
		logic       opnd_en;
		logic       div_start;
		logic       exec;       // perform the instruction
		logic       rd_cap;     // capture read item word
		logic       res_load;   // build result
	} rmc_cmd_t;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [15:0] opcode;
		logic        stopped;
		logic        div_busy;
	} rmc_sts_t;

	// operand count after the opcode
	function automatic logic [1:0] opnd_count(input logic [15:0] op);
		logic [1:0] n;
		n = 2'd0;
		if (op == OP_IN || op == OP_OUT || op == OP_EXEC || op == OP_JUMP ||
				op == OP_CALL)
			n = 2'd1;
		else if ((op >= OP_ADD && op <= OP_XOR) || (op >= OP_LSH && op <= OP_BLE))
			n = 2'd3;
		else if (op <= OP_NOT && op != OP_RET)
			n = 2'd2;
		return n;
	endfunction

endpackage

// ===== hw/rtl/rmc_div.sv =====
// iterative signed divider, one quotient bit per cycle
module rmc_div import rmc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [15:0] dividend,
	input  logic [15:0] divisor,
	output logic        busy,
	output logic [15:0] quot,
	output logic [15:0] rem
);

	logic [4:0]  cnt_q;
	logic [15:0] q_q;
	logic [15:0] r_q;
	logic [15:0] d_q;
	logic        qneg_q, rneg_q;
	logic [16:0] trial;
	logic [16:0] rsh;

	assign busy = (cnt_q != 5'd0);
	assign rsh = {r_q, q_q[15]};
	assign trial = rsh - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 5'd0;
		end else if (start) begin
			cnt_q <= 5'd16;
		end else if (busy) begin
			cnt_q <= cnt_q - 5'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= dividend[15] ? 16'(-dividend) : dividend;
			d_q <= divisor[15] ? 16'(-divisor) : divisor;
			r_q <= 16'd0;
			qneg_q <= dividend[15] ^ divisor[15];
			rneg_q <= dividend[15];
		end else if (busy) begin
			if (!trial[16]) begin
				r_q <= trial[15:0];
				q_q <= {q_q[14:0], 1'b1};
			end else begin
				r_q <= rsh[15:0];
				q_q <= {q_q[14:0], 1'b0};
			end
		end
	end

	assign quot = qneg_q ? 16'(-q_q) : q_q;
	assign rem = rneg_q ? 16'(-r_q) : r_q;

endmodule

// ===== hw/rtl/rmc_datapath.sv =====
// datapath: memory, registers, return stack, pc, alu and result register
module rmc_datapath import rmc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  rmc_cmd_t    cmd,
	output rmc_sts_t    sts,
	input  logic [1:0]  in_type,
	input  logic [14:0] in_addr,
	input  logic [15:0] in_wword,
	input  logic [8:0]  in_char,
	output logic [42:0] res
);

	logic [15:0] mem [MemWords];
	logic [15:0] mem_rdata_q;
	logic [15:0] regs_q [RegCount];
	logic [14:0] rstk [RetDepth];
	logic [RetDepth-1:0] rvld_q;
	logic [14:0] rret_q;
	logic        rret_vld_q;
	logic [SpW-1:0] sp_q;
	logic [SpW-1:0] sp_dec;
	logic [14:0] pc_q;
	logic [1:0]  stop_q;
	logic [1:0]  type_q;
	logic [14:0] addr_q;
	logic [15:0] wword_q;
	logic [8:0]  char_q;
	logic [15:0] op_q, x_q, y_q, z_q;
	logic [15:0] rdw_q;
	logic        outv_q, intk_q;
	logic [7:0]  outc_q;
	logic [15:0] mul_q;
	logic [MemAw-1:0] maddr;
	logic [15:0] a, b, xr, alu;
	logic        wr_reg, cond, dv_busy;
	logic [15:0] dq, dr;
	logic [RegAw-1:0] ix, iy, iz;

	assign ix = x_q[RegAw-1:0];
	assign iy = y_q[RegAw-1:0];
	assign iz = z_q[RegAw-1:0];
	assign a = regs_q[iy];
	assign b = regs_q[iz];
	assign xr = regs_q[ix];
	assign sp_dec = sp_q - SpW'(1);

	always_comb begin
		unique case (cmd.mem_sel)
			MA_REQ: maddr = addr_q[MemAw-1:0];
			MA_PC:  maddr = pc_q[MemAw-1:0];
			MA_OPY: maddr = y_q[MemAw-1:0];
			MA_OPX: maddr = x_q[MemAw-1:0];
			default: maddr = addr_q[MemAw-1:0];
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.mem_wr_req)
			mem[maddr] <= wword_q;
		else if (cmd.mem_wr_st)
			mem[maddr] <= y_q;
		if (cmd.mem_rd)
			mem_rdata_q <= mem[maddr];
	end

	// return stack: top entry is read every cycle, sp is steady before a ret executes
	always_ff @(posedge clk) begin
		if (cmd.exec && op_q == OP_CALL)
			rstk[sp_q] <= pc_q + 15'd1;
		rret_q <= rstk[sp_dec];
	end

	rmc_div u_div (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start),
		.dividend(a), .divisor(b), .busy(dv_busy), .quot(dq), .rem(dr)
	);

	always_comb begin
		wr_reg = 1'b1;
		alu = 16'd0;
		case (op_q)
			OP_LDC: alu = y_q;
			OP_LD:  alu = mem_rdata_q;
			OP_CP:  alu = a;
			OP_IN:  alu = {{7{char_q[8]}}, char_q};
			OP_INC: alu = a + 16'd1;
			OP_DEC: alu = a - 16'd1;
			OP_ADD: alu = a + b;
			OP_SUB: alu = a - b;
			OP_MUL: alu = mul_q;
			OP_DIV: alu = (b == 16'd0) ? 16'hFFFF : dq;
			OP_MOD: alu = (b == 16'd0) ? a : dr;
			OP_AND: alu = a & b;
			OP_OR:  alu = a | b;
			OP_XOR: alu = a ^ b;
			OP_NOT: alu = ~a;
			OP_LSH: alu = (b >= 16'd16) ? 16'd0 : (a << b[3:0]);
			OP_RSH: alu = (b >= 16'd16) ? {16{a[15]}} : 16'($signed(a) >>> b[3:0]);
			default: wr_reg = 1'b0;
		endcase
		case (op_q)
			OP_BEQ: cond = $signed(a) == $signed(b);
			OP_BNE: cond = $signed(a) != $signed(b);
			OP_BGT: cond = $signed(a) > $signed(b);
			OP_BGE: cond = $signed(a) >= $signed(b);
			OP_BLT: cond = $signed(a) < $signed(b);
			OP_BLE: cond = $signed(a) <= $signed(b);
			default: cond = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			type_q <= in_type;
			addr_q <= in_addr;
			wword_q <= in_wword;
			char_q <= in_char;
		end
		if (cmd.opnd_en) begin
			case (cmd.opnd_wr)
				2'd0: begin
					op_q <= mem_rdata_q;
					x_q <= 16'd0;
					y_q <= 16'd0;
					z_q <= 16'd0;
				end
				2'd1: x_q <= mem_rdata_q;
				2'd2: y_q <= mem_rdata_q;
				default: z_q <= mem_rdata_q;
			endcase
		end
		mul_q <= 16'(a * b);
		if (cmd.rd_cap)
			rdw_q <= mem_rdata_q;
		else if (cmd.load_req)
			rdw_q <= 16'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < RegCount; i++) regs_q[i] <= 16'd0;
			rvld_q <= '0;
			rret_vld_q <= 1'b0;
			sp_q <= '0;
			pc_q <= 15'd0;
			stop_q <= STOP_RUN;
			outv_q <= 1'b0;
			intk_q <= 1'b0;
			outc_q <= 8'd0;
		end else begin
			rret_vld_q <= rvld_q[sp_dec];
			if (cmd.load_req) begin
				outv_q <= 1'b0;
				intk_q <= 1'b0;
				outc_q <= 8'd0;
			end
			if (cmd.pc_inc)
				pc_q <= pc_q + 15'd1;
			if (cmd.exec) begin
				if (wr_reg)
					regs_q[ix] <= alu;
				if (op_q == OP_IN)
					intk_q <= 1'b1;
				if (op_q == OP_OUT) begin
					outv_q <= 1'b1;
					outc_q <= xr[7:0];
				end
				if (cond || op_q == OP_JUMP)
					pc_q <= x_q[14:0];
				if (op_q == OP_EXEC)
					pc_q <= xr[14:0];
				if (op_q == OP_CALL) begin
					rvld_q[sp_q] <= 1'b1;
					sp_q <= sp_q + SpW'(1);
					pc_q <= x_q[14:0];
				end
				if (op_q == OP_RET) begin
					sp_q <= sp_dec;
					// entries never pushed read as zero
					pc_q <= rret_vld_q ? rret_q : 15'd0;
				end
				if (op_q == OP_HALT)
					stop_q <= STOP_HALT;
				else if (op_q == OP_DUMP)
					stop_q <= STOP_DUMP;
				else if (op_q > OP_DUMP)
					stop_q <= STOP_INVALID;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load)
			res <= {pc_q, stop_q, intk_q, outc_q, outv_q, rdw_q};
	end

	assign sts.req_type = type_q;
	assign sts.opcode = op_q;
	assign sts.stopped = (stop_q != STOP_RUN);
	assign sts.div_busy = dv_busy;

endmodule

// ===== hw/rtl/rmc_ctrl.sv =====
// controller: sequences request dispatch, item reads and writes, fetch, operand reads, execution and result handoff
module rmc_ctrl import rmc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     s_tvalid,
	output logic     s_tready,
	output logic     m_tvalid,
	input  logic     m_tready,
	input  rmc_sts_t sts,
	output rmc_cmd_t cmd
);

	typedef enum logic [9:0] {
		ST_IDLE   = 10'b0000000001,
		ST_DISP   = 10'b0000000010,
		ST_RDWAIT = 10'b0000000100,
		ST_FETCH  = 10'b0000001000,
		ST_OPND   = 10'b0000010000,
		ST_PREP   = 10'b0000100000,
		ST_DIVW   = 10'b0001000000,
		ST_EXEC   = 10'b0010000000,
		ST_RES    = 10'b0100000000,
		ST_OUT    = 10'b1000000000
	} state_t;

	state_t state_q, state_d;
	logic [1:0] idx_q, idx_d; // next operand slot
	logic [1:0] need;

	assign need = opnd_count(sts.opcode);
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = (state_q == ST_OUT);

	always_comb begin
		state_d = state_q;
		idx_d = idx_q;
		cmd = '0;
		cmd.mem_sel = MA_REQ;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.load_req = 1'b1;
					state_d = ST_DISP;
				end
			end
			ST_DISP: begin
				if (sts.req_type == REQ_WRITE) begin
					cmd.mem_wr_req = 1'b1;
					state_d = ST_RES;
				end else if (sts.req_type == REQ_READ) begin
					cmd.mem_rd = 1'b1;
					state_d = ST_RDWAIT;
				end else if (sts.req_type == REQ_STEP && !sts.stopped) begin
					cmd.mem_rd = 1'b1;
					cmd.mem_sel = MA_PC;
					cmd.pc_inc = 1'b1;
					state_d = ST_FETCH;
				end else begin
					state_d = ST_RES;
				end
			end
			ST_RDWAIT: begin
				cmd.rd_cap = 1'b1;
				state_d = ST_RES;
			end
			ST_FETCH: begin
				cmd.opnd_en = 1'b1;
				cmd.opnd_wr = 2'd0;
				idx_d = 2'd1;
				state_d = ST_OPND;
			end
			ST_OPND: begin
				// idx_q-1 operands captured so far; slot 0 after wrap is z
				if (idx_q != 2'd1) begin
					cmd.opnd_en = 1'b1;
					cmd.opnd_wr = idx_q - 2'd1;
				end
				if ((idx_q - 2'd1) < need && idx_q != 2'd0) begin
					cmd.mem_rd = 1'b1;
					cmd.mem_sel = MA_PC;
					cmd.pc_inc = 1'b1;
					idx_d = idx_q + 2'd1;
				end else begin
					state_d = ST_PREP;
				end
			end
			ST_PREP: begin
				// ld/st address now known; mul settles into its register
				if (sts.opcode == OP_LD) begin
					cmd.mem_rd = 1'b1;
					cmd.mem_sel = MA_OPY;
				end else if (sts.opcode == OP_ST) begin
					cmd.mem_wr_st = 1'b1;
					cmd.mem_sel = MA_OPX;
				end
				if (sts.opcode == OP_DIV || sts.opcode == OP_MOD) begin
					cmd.div_start = 1'b1;
					state_d = ST_DIVW;
				end else begin
					state_d = ST_EXEC;
				end
			end
			ST_DIVW: begin
				if (!sts.div_busy)
					state_d = ST_EXEC;
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				state_d = ST_RES;
			end
			ST_RES: begin
				cmd.res_load = 1'b1;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (m_tready)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q <= 2'd0;
		end else begin
			state_q <= state_d;
			idx_q <= idx_d;
		end
	end

`ifndef SYNTH
	a_onehot: assert property (@(posedge clk) disable iff (!arst_n) $onehot(state_q))
		else $error("state not one-hot");
	a_excl: assert property (@(posedge clk) disable iff (!arst_n) !(s_tready && m_tvalid))
		else $error("input and output open together");
	a_res: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RES) |=> m_tvalid)
		else $error("result not presented");
	a_wr: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.mem_wr_req && cmd.mem_wr_st))
		else $error("two memory writes");
`endif

endmodule

// ===== hw/rtl/register_machine_core_16bit_core.sv =====
// top level of the 16-bit register machine core
// One item in flight at a time. A write item, a step on a stopped machine or an
// unknown request goes from dispatch straight to the result; a read item first waits
// for its memory word. A step fetches the opcode and up to 3 operand words through
// the single memory port, and div/mod wait on the bit-serial divider. The input is
// ready again in the cycle after the output transfer. Memory holds garbage until
// written; reset clears the registers, stack pointer, pc and stop code at once, and
// return stack entries read as zero until a call pushes them.
module register_machine_core_16bit_core import rmc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [1:0]  s_tuser,  // req_type
	input  logic [39:0] s_tdata,  // mem_address[14:0], write_word[30:15], in_char[39:31]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata   // read_word, out_valid, out_char, in_taken, run_status, pc_now
);

	rmc_cmd_t cmd;
	rmc_sts_t sts;
	logic [42:0] res;

	rmc_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .sts(sts), .cmd(cmd)
	);

	rmc_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.in_type(s_tuser), .in_addr(s_tdata[14:0]), .in_wword(s_tdata[30:15]),
		.in_char(s_tdata[39:31]), .res(res)
	);

	assign m_tdata = {5'd0, res};

endmodule
